// ===== sv/adlc_pkg.sv =====
// Shared widths, register indexes, item codes and the tap control record.
package adlc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 12;
   localparam int LEN_W    = 13;
   localparam int STEP_W   = 18;
   localparam int MIX_W    = 17;
   localparam int IDX_W    = 2;
   localparam int PROD_W   = SAMPLE_W + 1 + MIX_W + 1;

   localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(65536);

   localparam logic [IDX_W-1:0] REG_DELAY     = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_BLOCK_LEN = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_RAMP_STEP = IDX_W'(2);

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_PAUSE  = 1'b1;

   // What the blend stage needs besides the two memory words. A mix of zero
   // selects the old tap and a mix of one selects the new tap exactly.
   typedef struct packed {
      logic                       fwd_old;
      logic                       fwd_new;
      logic signed [SAMPLE_W-1:0] sample;
      logic [MIX_W-1:0]           mix;
   } tap_ctl_type;

endpackage

// ===== sv/adlc_blend.sv =====
// Crossfade datapath: tap forwarding, difference times mix, then the final add.
module adlc_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                s1_valid,
   input  logic signed [adlc_pkg::SAMPLE_W-1:0] rd_old,
   input  logic signed [adlc_pkg::SAMPLE_W-1:0] rd_new,
   input  adlc_pkg::tap_ctl_type               ctl,
   output logic                                s2_valid,
   output logic signed [adlc_pkg::SAMPLE_W-1:0] result
);
   import adlc_pkg::*;

   logic signed [SAMPLE_W-1:0] old_s;
   logic signed [SAMPLE_W-1:0] new_s;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SAMPLE_W-1:0] base_ff;
   logic                       s2_valid_ff;
   logic signed [PROD_W-16:0]  sum;

   // A tap that lands on the entry written in the same cycle takes the sample.
   assign old_s   = ctl.fwd_old ? ctl.sample : rd_old;
   assign new_s   = ctl.fwd_new ? ctl.sample : rd_new;
   assign diff    = (SAMPLE_W+1)'(new_s) - (SAMPLE_W+1)'(old_s);
   assign prod_in = PROD_W'(diff) * PROD_W'($signed({1'b0, ctl.mix}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         base_ff <= old_s;
      end
   end

   // old*65536 is a multiple of 65536, so the floor only touches the product.
   assign sum      = (PROD_W-15)'(base_ff) + $signed(prod_ff[PROD_W-1:16]);
   assign result   = sum[SAMPLE_W-1:0];
   assign s2_valid = s2_valid_ff;

endmodule

// ===== sv/audio_delay_line_crossfade.sv =====
// Ring-memory delay line with a linear crossfade when the delay changes.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_op, req_sample_in
//   rsp     | out       | rsp_valid, rsp_ready, rsp_sample_out
//   csr     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// One sample item is taken per cycle while req_ready is high; its result passes
// through the memory read, multiply and output registers. A pause item on an
// uncleared memory, and reset itself, start a clearing pass that writes one
// entry per cycle; req_ready is low during that pass. A stalled rsp side
// holds the whole pipeline, and csr writes are always taken.
module audio_delay_line_crossfade #(
   parameter int DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [adlc_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [adlc_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [adlc_pkg::IDX_W-1:0]           csr_index,
   input  logic [adlc_pkg::STEP_W-1:0]          csr_data
);
   import adlc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = (AW > DELAY_W) ? AW : DELAY_W;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];

   // Configuration registers.
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [LEN_W-1:0]   block_len_ff, block_len_in;
   logic [STEP_W-1:0]  ramp_step_ff, ramp_step_in;

   // Control state.
   logic [AW-1:0]      wp_ff, wp_in;
   logic [DELAY_W-1:0] prev_delay_ff, prev_delay_in;
   logic               pending_ff, pending_in;
   logic               active_ff, active_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [MIX_W-1:0]   mix_ff, mix_in;
   logic               cleared_ff, cleared_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   // Pipeline.
   logic                       s1_valid_ff;
   tap_ctl_type                s1_ctl_ff, s1_ctl_in;
   logic signed [SAMPLE_W-1:0] rd_old_ff;
   logic signed [SAMPLE_W-1:0] rd_new_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;
   logic                       s2_valid;
   logic signed [SAMPLE_W-1:0] blend_result;

   logic               advance;
   logic               accept;
   logic               take_sample;
   logic               take_pause;
   logic               csr_write;
   logic [LEN_W-1:0]   len;
   logic               start;
   logic               act_now;
   logic               pend_now;
   logic [MIX_W-1:0]   mix_now;
   logic [LEN_W:0]     pos_inc;
   logic [MIX_W+1:0]   mix_sum;
   logic [SW-1:0]      old_diff;
   logic [SW-1:0]      new_diff;
   logic [AW-1:0]      idx_old;
   logic [AW-1:0]      idx_new;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = advance && !clr_busy_ff;
   assign accept      = req_valid && req_ready;
   assign take_sample = accept && (req_op == OP_SAMPLE);
   assign take_pause  = accept && (req_op == OP_PAUSE);
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;

   // Tap addresses are taken modulo the ring size.
   assign old_diff = SW'(wp_ff) - SW'(prev_delay_ff);
   assign new_diff = SW'(wp_ff) - SW'(delay_ff);
   assign idx_old  = old_diff[AW-1:0];
   assign idx_new  = new_diff[AW-1:0];

   always_comb begin
      len      = (block_len_ff == '0) ? LEN_W'(1) : block_len_ff;
      start    = (pos_ff == '0) && pending_ff;
      act_now  = active_ff || start;
      pend_now = pending_ff && !start;
      mix_now  = start ? '0 : mix_ff;
      pos_inc  = (LEN_W+1)'(pos_ff) + (LEN_W+1)'(1);
      mix_sum  = (MIX_W+2)'(mix_now) + (MIX_W+2)'(ramp_step_ff);

      delay_in      = delay_ff;
      block_len_in  = block_len_ff;
      ramp_step_in  = ramp_step_ff;
      wp_in         = wp_ff;
      prev_delay_in = prev_delay_ff;
      pending_in    = pending_ff;
      active_in     = active_ff;
      pos_in        = pos_ff;
      mix_in        = mix_ff;
      cleared_in    = cleared_ff;
      clr_busy_in   = clr_busy_ff;
      clr_addr_in   = clr_addr_ff;

      s1_ctl_in.fwd_old = (idx_old == wp_ff);
      s1_ctl_in.fwd_new = (idx_new == wp_ff);
      s1_ctl_in.sample  = req_sample_in;
      s1_ctl_in.mix     = MIX_ONE;

      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      if (take_pause && !cleared_ff) begin
         cleared_in  = 1'b1;
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end

      if (take_sample) begin
         cleared_in = 1'b0;
         wp_in      = wp_ff + AW'(1);
         pending_in = pend_now;
         mix_in     = mix_now;
         if (act_now) begin
            if (pos_ff < (len >> 1)) begin
               s1_ctl_in.mix = '0;
            end else begin
               s1_ctl_in.mix = mix_now;
               mix_in = (mix_sum > (MIX_W+2)'(MIX_ONE)) ? MIX_ONE : mix_sum[MIX_W-1:0];
            end
         end else if (pend_now) begin
            s1_ctl_in.mix = '0;
         end
         // A block position at or past the length ends the block here.
         if (pos_inc >= (LEN_W+1)'(len)) begin
            pos_in    = '0;
            active_in = 1'b0;
         end else begin
            pos_in    = pos_inc[LEN_W-1:0];
            active_in = act_now;
         end
      end

      if (csr_write) begin
         unique case (csr_index)
            REG_DELAY: begin
               prev_delay_in = delay_ff;
               delay_in      = csr_data[DELAY_W-1:0];
               pending_in    = 1'b1;
            end
            REG_BLOCK_LEN: begin
               block_len_in = csr_data[LEN_W-1:0];
            end
            REG_RAMP_STEP: begin
               ramp_step_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= '0;
         block_len_ff  <= LEN_W'(512);
         ramp_step_ff  <= STEP_W'(256);
         wp_ff         <= '0;
         prev_delay_ff <= '0;
         pending_ff    <= 1'b0;
         active_ff     <= 1'b0;
         pos_ff        <= '0;
         mix_ff        <= '0;
         cleared_ff    <= 1'b0;
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         delay_ff      <= delay_in;
         block_len_ff  <= block_len_in;
         ramp_step_ff  <= ramp_step_in;
         wp_ff         <= wp_in;
         prev_delay_ff <= prev_delay_in;
         pending_ff    <= pending_in;
         active_ff     <= active_in;
         pos_ff        <= pos_in;
         mix_ff        <= mix_in;
         cleared_ff    <= cleared_in;
         clr_busy_ff   <= clr_busy_in;
         clr_addr_ff   <= clr_addr_in;
         if (advance) begin
            s1_valid_ff  <= take_sample;
            rsp_valid_ff <= s2_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= blend_result;
      end
      if (take_sample) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Ring memory: one write port, two read ports with registered data.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (take_sample) begin
         mem[wp_ff] <= req_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         rd_old_ff <= mem[idx_old];
         rd_new_ff <= mem[idx_new];
      end
   end

   adlc_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .s1_valid (s1_valid_ff),
      .rd_old   (rd_old_ff),
      .rd_new   (rd_new_ff),
      .ctl      (s1_ctl_ff),
      .s2_valid (s2_valid),
      .result   (blend_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// ===== bench/adlc_stream_checker.sv =====
// Stream checker for the delay line: tracks the block's state, predicts each result, compares.
`timescale 1ns / 100ps

module adlc_stream_checker #(
   parameter int DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [adlc_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [adlc_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [adlc_pkg::IDX_W-1:0]           csr_index,
   input  logic [adlc_pkg::STEP_W-1:0]          csr_data,
   input  logic                                 end_of_run,
   output int                                   fail_count,
   output int                                   expected_pending,
   output int                                   results_checked,
   output int                                   ramps_started,
   output int                                   clears_done
);
   import adlc_pkg::*;

   localparam int MAX_REPORTS = 40;

   // Shadow copy of the block's state and registers.
   logic signed [SAMPLE_W-1:0] delay_mem [DEPTH];
   logic [DELAY_W-1:0]         wr_ptr;
   logic [DELAY_W-1:0]         old_delay;
   logic [DELAY_W-1:0]         cur_delay;
   logic [LEN_W-1:0]           blk_len;
   logic [STEP_W-1:0]          step;
   logic                       ramp_armed;
   logic                       ramp_running;
   logic                       mem_is_clear;
   logic                       end_checked;
   int                         blk_pos;
   int unsigned                mix;

   logic signed [SAMPLE_W-1:0] expected_out_q [$];

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   task automatic clear_delay_mem();
      for (int i = 0; i < DEPTH; i++) begin
         delay_mem[i] = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      int                         len;
      longint                     mixed;
      logic signed [SAMPLE_W-1:0] old_tap;
      logic signed [SAMPLE_W-1:0] new_tap;
      logic signed [SAMPLE_W-1:0] out_s;
      logic signed [SAMPLE_W-1:0] wanted;

      if (reset) begin
         clear_delay_mem();
         wr_ptr          = '0;
         old_delay       = '0;
         cur_delay       = '0;
         blk_len         = LEN_W'(512);
         step            = STEP_W'(256);
         ramp_armed      = 1'b0;
         ramp_running    = 1'b0;
         mem_is_clear    = 1'b0;
         end_checked     = 1'b0;
         blk_pos         = 0;
         mix             = 0;
         fail_count      = 0;
         results_checked = 0;
         ramps_started   = 0;
         clears_done     = 0;
         expected_out_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY: begin
                  old_delay  = cur_delay;
                  cur_delay  = csr_data[DELAY_W-1:0];
                  ramp_armed = 1'b1;
               end
               REG_BLOCK_LEN: blk_len = csr_data[LEN_W-1:0];
               REG_RAMP_STEP: step = csr_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (req_op == OP_PAUSE) begin
               // Only the first pause after reset or after audio wipes the memory.
               if (!mem_is_clear) begin
                  clear_delay_mem();
                  mem_is_clear = 1'b1;
                  clears_done++;
               end
            end else begin
               mem_is_clear = 1'b0;
               delay_mem[wr_ptr] = req_sample_in;
               len = (blk_len == 0) ? 1 : int'(blk_len);
               if (blk_pos == 0 && ramp_armed) begin
                  ramp_running = 1'b1;
                  ramp_armed   = 1'b0;
                  mix          = 0;
                  ramps_started++;
               end

               old_tap = delay_mem[(wr_ptr - old_delay) & (DEPTH - 1)];
               new_tap = delay_mem[(wr_ptr - cur_delay) & (DEPTH - 1)];

               if (ramp_running) begin
                  if (blk_pos < len / 2) begin
                     out_s = old_tap;
                  end else begin
                     mixed = longint'(old_tap) * 65536
                           + (longint'(new_tap) - longint'(old_tap)) * longint'(mix);
                     out_s = SAMPLE_W'(mixed >>> 16);
                     mix += step;
                     if (mix > MIX_ONE) begin
                        mix = MIX_ONE;
                     end
                  end
               end else begin
                  // An armed ramp that has not started yet keeps the old tap.
                  out_s = ramp_armed ? old_tap : new_tap;
               end

               wr_ptr = wr_ptr + 1'b1;
               blk_pos++;
               if (blk_pos >= len) begin
                  blk_pos      = 0;
                  ramp_running = 1'b0;
               end
               expected_out_q.push_back(out_s);
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_out_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         rsp_sample_out));
            end else begin
               wanted = expected_out_q.pop_front();
               results_checked++;
               if (rsp_sample_out !== wanted) begin
                  report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                            results_checked, rsp_sample_out, wanted));
               end
            end
         end

         if (end_of_run && !end_checked) begin
            end_checked = 1'b1;
            if (expected_out_q.size() != 0) begin
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_out_q.size()));
            end
         end
      end
      expected_pending = expected_out_q.size();
   end

endmodule

// ===== bench/audio_delay_line_crossfade_tb.sv =====
// Top of the delay line bench: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module audio_delay_line_crossfade_tb;
   import adlc_pkg::*;

   localparam int     DEPTH            = 4096;
   localparam int     ITEM_TARGET      = 1900;
   localparam int     SETTLE_CYCLES    = 6;
   localparam int     DRAIN_CYCLES     = 20;
   localparam int     LONG_HOLD_CYCLES = 200;
   localparam int     HOLD_PHASE       = 8;
   localparam longint TIMEOUT_NS       = 64'd18_000_000;

   localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);

   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_op;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [IDX_W-1:0]           csr_index;
   logic [STEP_W-1:0]          csr_data;
   logic                       end_of_run;

   int fail_count;
   int expected_pending;
   int results_checked;
   int ramps_started;
   int clears_done;

   // no_gaps and long_hold_req are shared between the sender and the receiver processes.
   logic no_gaps;
   logic long_hold_req;
   int   samples_sent;
   int   pauses_sent;
   int   csr_writes;

   audio_delay_line_crossfade #(.DEPTH(DEPTH)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   adlc_stream_checker #(.DEPTH(DEPTH)) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .end_of_run       (end_of_run),
      .fail_count       (fail_count),
      .expected_pending (expected_pending),
      .results_checked  (results_checked),
      .ramps_started    (ramps_started),
      .clears_done      (clears_done)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results still expected", expected_pending);
      $display("end of test: mismatches");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 9) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      gap = (no_gaps || $urandom_range(0, 9) < 6) ? 0 : gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_op        = op;
      req_sample_in = smp;
      do @(posedge clock); while (!req_ready);
      if (op == OP_PAUSE) begin
         pauses_sent++;
      end else begin
         samples_sent++;
      end
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   // Registers change only once every result is back and the pipeline has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Result side back-pressure, with one long hold-off on request.
   initial begin : rsp_side
      int stretch;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (no_gaps || $urandom_range(0, 9) < 7) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b0;
            stretch = gap_len();
            repeat (stretch - 1) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int                         n;
      int                         phase;
      int                         r;
      int                         cur_len;
      logic [DELAY_W-1:0]         d;
      logic [LEN_W-1:0]           bl;
      logic [STEP_W-1:0]          st;
      logic signed [SAMPLE_W-1:0] smp;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_SAMPLE;
      req_sample_in = '0;
      csr_valid     = 1'b0;
      csr_index     = REG_DELAY;
      csr_data      = '0;
      end_of_run    = 1'b0;
      no_gaps       = 1'b0;
      long_hold_req = 1'b0;
      samples_sent  = 0;
      pauses_sent   = 0;
      csr_writes    = 0;
      cur_len       = 512;

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Pass-through at reset settings, with field extremes.
      send_item(OP_SAMPLE, SMP_MAX);
      send_item(OP_SAMPLE, SMP_MIN);
      send_item(OP_SAMPLE, -24'sd1);
      send_item(OP_SAMPLE, 24'sd0);
      send_item(OP_SAMPLE, 24'sd1);
      send_item(OP_SAMPLE, 24'sh555555);
      send_item(OP_SAMPLE, 24'shAAAAAA);
      // The second pause finds the memory already clear.
      send_item(OP_PAUSE, 24'sh0F0F0F);
      send_item(OP_PAUSE, 24'shF0F0F0);
      send_item(OP_SAMPLE, 24'sh123456);
      wait_idle();

      // Short block with a full-scale step; the block in progress is cut short.
      csr_write(REG_BLOCK_LEN, STEP_W'(4));
      csr_write(REG_RAMP_STEP, STEP_W'(65536));
      csr_write(REG_DELAY, STEP_W'(3));
      csr_write(REG_SPARE, '1);
      for (int i = 0; i < 8; i++) begin
         send_item(OP_SAMPLE, i[0] ? SMP_MIN : SMP_MAX);
      end
      wait_idle();

      // Largest delay wraps the ring; zero block length acts as one.
      csr_write(REG_DELAY, '1);
      csr_write(REG_BLOCK_LEN, '0);
      csr_write(REG_RAMP_STEP, '1);
      cur_len = 1;
      send_item(OP_SAMPLE, SMP_MAX);
      send_item(OP_SAMPLE, SMP_MIN);
      send_item(OP_SAMPLE, 24'sh7F00FF);
      wait_idle();

      phase = 0;
      while (samples_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 6) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
               d = '1;
            end else if (r == 1) begin
               d = '0;
            end else if (r < 14) begin
               d = DELAY_W'($urandom_range(0, 48));
            end else begin
               d = DELAY_W'($urandom);
            end
            // Bits above the register width must be ignored.
            csr_write(REG_DELAY, {6'($urandom), d});
         end
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 19);
            if (r < 8) begin
               bl = LEN_W'($urandom_range(1, 16));
            end else if (r < 14) begin
               bl = LEN_W'($urandom_range(17, 64));
            end else if (r < 17) begin
               bl = LEN_W'($urandom_range(65, 600));
            end else if (r == 17) begin
               bl = LEN_W'(4096);
            end else if (r == 18) begin
               bl = '0;
            end else begin
               bl = '1;
            end
            csr_write(REG_BLOCK_LEN, STEP_W'(bl));
            cur_len = (bl == 0) ? 1 : int'(bl);
         end
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 9);
            case (r)
               0: st = '0;
               1: st = STEP_W'(1);
               2: st = STEP_W'(65536);
               3: st = STEP_W'(131072);
               4: st = '1;
               5: st = STEP_W'($urandom);
               default: st = STEP_W'(131072 / cur_len);
            endcase
            csr_write(REG_RAMP_STEP, st);
         end

         no_gaps = ($urandom_range(0, 3) == 0);
         n = ($urandom_range(0, 4) < 4) ? $urandom_range(1, 40) : $urandom_range(60, 250);
         if (n > ITEM_TARGET - samples_sent) begin
            n = ITEM_TARGET - samples_sent;
         end
         if (phase == HOLD_PHASE) begin
            // Keep offering items while the result side holds off.
            no_gaps       = 1'b1;
            n             = 150;
            long_hold_req = 1'b1;
         end

         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 79) == 0) begin
               send_item(OP_PAUSE, SAMPLE_W'($urandom));
               if ($urandom_range(0, 2) == 0) begin
                  send_item(OP_PAUSE, SAMPLE_W'($urandom));
               end
            end
            r = $urandom_range(0, 19);
            case (r)
               0: smp = SMP_MAX;
               1: smp = SMP_MIN;
               default: smp = SAMPLE_W'($urandom);
            endcase
            send_item(OP_SAMPLE, smp);
         end
         wait_idle();
         phase++;
      end

      no_gaps = 1'b0;
      while (expected_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      end_of_run = 1'b1;
      @(negedge clock);

      $display("Covered %0d samples and %0d pauses in %0d phases with %0d register writes.",
               samples_sent, pauses_sent, phase, csr_writes);
      $display("Checked %0d results across %0d crossfade ramps and %0d memory clears.",
               results_checked, ramps_started, clears_done);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
